// ===== src/mac_address_peer_table_top_macros.svh =====
// Assertion macros for the MAC address peer table.
// Included by the top level; expects clk_i and rst_ni in the including scope.
`ifndef MAC_ADDRESS_PEER_TABLE_TOP_MACROS_SVH
`define MAC_ADDRESS_PEER_TABLE_TOP_MACROS_SVH

// Checked on every rising edge while out of reset.
`define MAPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MAPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/mapt_pkg.sv =====
// Shared types and constants of the MAC address peer table.
// No dependencies; used by mapt_cell and mac_address_peer_table_top.
package mapt_pkg;

  localparam int unsigned MAPT_TABLE_DEPTH = 16;
  localparam int unsigned MAPT_KEY_BYTES   = 6;
  localparam int unsigned MAPT_MAC_W       = 48;
  localparam int unsigned MAPT_CNT_OUT_W   = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } mapt_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } mapt_status_e;

  typedef enum logic [1:0] {
    MAPT_IDLE,
    MAPT_WALK,
    MAPT_DONE
  } mapt_state_e;

  typedef struct packed {
    logic tok;
    logic hit;
  } mapt_link_t;

endpackage

// ===== src/mac_address_peer_table_top.sv =====
// Top level of the MAC address peer table: request control, result register
// and the chain of entry cells. Depends on mapt_pkg, mapt_cell and the macro header.

// For each accepted request beat, a search token walks the chain of TABLE_DEPTH
// entry cells (16 by default) one cell per clock, and removal compacts the
// entries in the same pass. A finished result sits in the output register, so
// a new request beat is taken while the previous result beat still waits.
// There is no clearing pass after reset; the table starts empty.
`include "mac_address_peer_table_top_macros.svh"

module mac_address_peer_table_top import mapt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = MAPT_TABLE_DEPTH,
  parameter int unsigned KEY_BYTES   = MAPT_KEY_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // [47:0] mac_key
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [4:0] entry_count, [7:5] zero
  output logic [2:0]  m_axis_tuser_o   // [0] success, [2:1] status
);

  localparam int unsigned KEY_W = (8 * KEY_BYTES < MAPT_MAC_W) ? 8 * KEY_BYTES : MAPT_MAC_W;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  mapt_state_e  state_q, state_d;
  logic [1:0]   op_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic         launch_q;
  logic         success_q, success_d;
  mapt_status_e status_q, status_d;
  logic         m_valid_q, m_valid_d;
  logic [2:0]   m_user_q;
  logic [MAPT_CNT_OUT_W-1:0] m_count_q;
  logic         accept;
  logic         load_out;
  logic         add_wr;
  logic         done;
  logic         found;

  mapt_link_t       link_w  [TABLE_DEPTH+1];
  logic [KEY_W-1:0] entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tok_vec;

  assign link_w[0] = '{tok: launch_q, hit: 1'b0};
  assign done      = link_w[TABLE_DEPTH].tok;
  assign found     = link_w[TABLE_DEPTH].hit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] next_entry;
    if (i + 1 < TABLE_DEPTH) begin : g_mid
      assign next_entry = entry_w[i+1];
    end else begin : g_last
      assign next_entry = entry_w[i];
    end
    assign tok_vec[i] = link_w[i+1].tok;

    mapt_cell #(
      .INDEX(i),
      .KEY_W(KEY_W),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .link_i      (link_w[i]),
      .link_o      (link_w[i+1]),
      .key_i       (key_q),
      .count_i     (count_q),
      .remove_i    (op_q == OP_REMOVE),
      .wr_en_i     (add_wr && (count_q == CNT_W'(i))),
      .next_entry_i(next_entry),
      .entry_o     (entry_w[i])
    );
  end

  assign s_axis_tready_o = (state_q == MAPT_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    success_d = success_q;
    status_d  = status_q;
    add_wr    = 1'b0;
    load_out  = 1'b0;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    unique case (state_q)
      MAPT_IDLE: begin
        if (accept) begin
          state_d = MAPT_WALK;
        end
      end
      MAPT_WALK: begin
        if (done) begin
          state_d = MAPT_DONE;
          unique case (op_q)
            OP_ADD: begin
              if (found) begin
                success_d = 1'b0;
                status_d  = ST_PRESENT;
              end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                success_d = 1'b0;
                status_d  = ST_FULL;
              end else begin
                success_d = 1'b1;
                status_d  = ST_OK;
                add_wr    = 1'b1;
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              success_d = found;
              status_d  = found ? ST_OK : ST_ABSENT;
              if (found) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            default: begin
              success_d = found;
              status_d  = found ? ST_OK : ST_ABSENT;
            end
          endcase
        end
      end
      MAPT_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = MAPT_IDLE;
        end
      end
      default: begin
        state_d = MAPT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= MAPT_IDLE;
      count_q   <= '0;
      launch_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      launch_q  <= accept;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[KEY_W-1:0];
    end
    success_q <= success_d;
    status_q  <= status_d;
    if (load_out) begin
      m_user_q  <= {status_q, success_q};
      m_count_q <= MAPT_CNT_OUT_W'(count_q);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tdata_o  = {(8 - MAPT_CNT_OUT_W)'(0), m_count_q};

  `MAPT_ASSERT(a_count_range, count_q <= CNT_W'(TABLE_DEPTH), "entry count exceeds depth")
  `MAPT_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec), "more than one search token in the chain")
  `MAPT_ASSERT(a_add_grows, add_wr |=> count_q == $past(count_q) + CNT_W'(1),
               "add did not grow count")
  `MAPT_ASSERT(a_ok_flag,
               m_axis_tvalid_o |-> (m_axis_tuser_o[0] == (m_axis_tuser_o[2:1] == ST_OK)),
               "success flag disagrees with status")

endmodule

// ===== src/mapt_cell.sv =====
// One table entry with its comparator and its stage of the search token chain.
// Depends on mapt_pkg.
module mapt_cell import mapt_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned KEY_W = MAPT_MAC_W,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mapt_link_t       link_i,
  output mapt_link_t       link_o,
  input  logic [KEY_W-1:0] key_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic             remove_i,
  input  logic             wr_en_i,
  input  logic [KEY_W-1:0] next_entry_i,
  output logic [KEY_W-1:0] entry_o
);

  logic [KEY_W-1:0] entry_q;
  mapt_link_t       link_q;
  logic             valid;
  logic             hit;

  assign valid = CNT_W'(INDEX) < count_i;
  assign hit   = link_i.hit | (valid && (entry_q == key_i));

  // Once the first match has been seen, every cell from there on pulls its
  // upper neighbor down as the token passes.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= key_i;
    end else if (link_i.tok && remove_i && hit) begin
      entry_q <= next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q.tok <= link_i.tok;
      link_q.hit <= link_i.tok & hit;
    end
  end

  assign link_o  = link_q;
  assign entry_o = entry_q;

endmodule
